// ----- rtl/stas_pkg.sv -----
// Shared types and constants of the sprite tile animation sequencer.
package stas_pkg;

    localparam int TILE_W    = 16;
    localparam int OFFSET_W  = 28;
    localparam int PIXEL_W   = 12;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;
    localparam int OPND_W    = 17;
    localparam int STEP_W    = 5;

    // Restoring remainder over a 17-bit dividend, shift-add over a 12-bit factor
    localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(OPND_W);
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(PIXEL_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SET   = 3'd3,
        CMD_NEXT  = 3'd4,
        CMD_PREV  = 3'd5
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_REP = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_ACR  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HGT   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP       = 4'd7;

    typedef enum logic {
        OP_MOD = 1'b0,
        OP_MUL = 1'b1
    } op_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [OPND_W-1:0] opa;
        logic [OPND_W-1:0] opb;
    } unit_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [OFFSET_W-1:0] result;
    } unit_stat_t;

endpackage

// ----- rtl/stas_if.sv -----
// Handshake channel interfaces: commands, results and register writes.
interface stas_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [stas_pkg::CMD_W-1:0]     command;
    logic [stas_pkg::TILE_W-1:0]    tile_number;

    modport source (output valid, output command, output tile_number, input ready);
    modport sink   (input valid, input command, input tile_number, output ready);
endinterface

interface stas_res_if;
    logic                           valid;
    logic                           ready;
    logic [stas_pkg::TILE_W-1:0]    tile_index;
    logic [stas_pkg::OFFSET_W-1:0]  source_x;
    logic [stas_pkg::OFFSET_W-1:0]  source_y;
    logic                           animating;
    logic                           at_end;

    modport source (output valid, output tile_index, output source_x, output source_y,
                    output animating, output at_end, input ready);
    modport sink   (input valid, input tile_index, input source_x, input source_y,
                    input animating, input at_end, output ready);
endinterface

interface stas_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [stas_pkg::CFG_IDX_W-1:0]    index;
    logic [stas_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sprite_tile_animation_sequencer.sv -----
// Sprite sheet tile animation sequencer: command decode, state and sequencer.
//
// Channels: cmd takes one command beat (tick, start, stop, set tile, next,
// previous); res returns exactly one beat per command with the tile index,
// its pixel offset in the sheet and the running / end flags; cfg writes the
// eight configuration registers by index and is always ready.
// A command is accepted only while the sequencer is idle. The tile offset
// is a 12-step shift-add on the shared unit. Set tile (with a new value)
// and next first run a 17-step restoring remainder on the same unit. The
// shared adder is used once per step; a command holds the sequencer until
// its result is loaded into the result register.
// The result register parts the two sides: the next command is accepted
// while an earlier result still waits on res. If res stalls when a new
// result completes, the sequencer holds until the register frees.
// Reset clears the animation state (tile 0, stopped, frame count 0) and
// loads register defaults: horizontal sheet, one frame per tile, one frame
// of repeat wait, one tile across and down, zero tile size, no looping.
// Write registers only while the block is idle.
module sprite_tile_animation_sequencer
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    stas_cmd_if.sink   cmd,
    stas_res_if.source res,
    stas_cfg_if.sink   cfg
);

    localparam int CMP_W = (COUNT_WIDTH > stas_pkg::TILE_W) ? COUNT_WIDTH : stas_pkg::TILE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_MUL  = 4'b0100,
        S_HOLD = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic                            horiz_reg;
    logic [stas_pkg::TILE_W-1:0]     fpt_reg;
    logic [stas_pkg::TILE_W-1:0]     fbr_reg;
    logic [stas_pkg::TILE_W-1:0]     across_reg;
    logic [stas_pkg::TILE_W-1:0]     down_reg;
    logic [stas_pkg::PIXEL_W-1:0]    twidth_reg;
    logic [stas_pkg::PIXEL_W-1:0]    theight_reg;
    logic                            loop_reg;

    // animation state
    logic [COUNT_WIDTH-1:0]          fc_reg, fc_next;
    logic [stas_pkg::TILE_W-1:0]     tile_reg, tile_next;
    logic                            end_reg, end_next;
    logic                            run_reg, run_next;

    // result register
    logic                            rv_reg, rv_next;
    logic [stas_pkg::TILE_W-1:0]     r_tile_reg;
    logic [stas_pkg::OFFSET_W-1:0]   r_x_reg;
    logic [stas_pkg::OFFSET_W-1:0]   r_y_reg;
    logic                            r_anim_reg;
    logic                            r_end_reg;

    stas_pkg::unit_req_t             req;
    stas_pkg::unit_stat_t            stat;

    logic                            accept;
    logic                            out_free;
    logic                            load;
    logic [stas_pkg::TILE_W-1:0]     count_sel;
    logic [stas_pkg::TILE_W-1:0]     count_m1;
    logic [stas_pkg::OPND_W-1:0]     count_full;
    logic [COUNT_WIDTH-1:0]          fc_inc;
    logic [stas_pkg::TILE_W-1:0]     tile_inc;
    logic [stas_pkg::PIXEL_W-1:0]    factor;
    logic                            need_mod;
    logic [stas_pkg::OPND_W-1:0]     mod_arg;

    stas_iter_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !rv_reg || res.ready;
    assign load      = (((state_reg == S_MUL) && stat.done) || (state_reg == S_HOLD))
                       && out_free;

    always_comb
    begin
        count_sel  = horiz_reg ? across_reg : down_reg;
        count_m1   = count_sel - 1'b1;
        // zero count reads as 65536
        count_full = (count_sel == '0) ? {1'b1, {stas_pkg::TILE_W{1'b0}}}
                                       : {1'b0, count_sel};
        fc_inc     = fc_reg + 1'b1;
        tile_inc   = tile_reg + 1'b1;
        factor     = horiz_reg ? twidth_reg : theight_reg;
    end

    // command decode for the accept cycle
    always_comb
    begin
        fc_next   = fc_reg;
        tile_next = tile_reg;
        end_next  = end_reg;
        run_next  = run_reg;
        need_mod  = 1'b0;
        mod_arg   = {1'b0, cmd.tile_number};
        case (cmd.command)
            stas_pkg::CMD_TICK:
            begin
                if (run_reg && !end_reg)
                begin
                    fc_next = fc_inc;
                    if (CMP_W'(fc_inc) >= CMP_W'(fpt_reg))
                    begin
                        fc_next   = '0;
                        tile_next = tile_inc;
                        if (tile_inc == count_m1)
                        begin
                            end_next = 1'b1;
                        end
                    end
                end
                else if (run_reg && loop_reg)
                begin
                    fc_next = fc_inc;
                    if (CMP_W'(fc_inc) >= CMP_W'(fbr_reg))
                    begin
                        fc_next   = '0;
                        end_next  = 1'b0;
                        tile_next = '0;
                    end
                end
            end
            stas_pkg::CMD_START:
            begin
                run_next  = 1'b1;
                end_next  = 1'b0;
                tile_next = '0;
            end
            stas_pkg::CMD_STOP:
            begin
                run_next = 1'b0;
            end
            stas_pkg::CMD_SET:
            begin
                need_mod = (cmd.tile_number != tile_reg);
            end
            stas_pkg::CMD_NEXT:
            begin
                need_mod = 1'b1;
                mod_arg  = stas_pkg::OPND_W'(tile_reg) + 1'b1;
            end
            stas_pkg::CMD_PREV:
            begin
                tile_next = (tile_reg != '0) ? (tile_reg - 1'b1) : count_m1;
            end
            default:
            begin
                tile_next = tile_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        req.start  = 1'b0;
        req.op     = stas_pkg::OP_MUL;
        req.opa    = stas_pkg::OPND_W'(tile_next);
        req.opb    = stas_pkg::OPND_W'(factor);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req.start = 1'b1;
                    if (need_mod)
                    begin
                        req.op     = stas_pkg::OP_MOD;
                        req.opa    = mod_arg;
                        req.opb    = count_full;
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MOD:
            begin
                req.opa = stas_pkg::OPND_W'(stat.result[stas_pkg::TILE_W-1:0]);
                if (stat.done)
                begin
                    req.start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (stat.done)
                begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rv_next = rv_reg;
        if (load)
        begin
            rv_next = 1'b1;
        end
        else if (res.ready)
        begin
            rv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            horiz_reg   <= 1'b1;
            fpt_reg     <= stas_pkg::TILE_W'(1);
            fbr_reg     <= stas_pkg::TILE_W'(1);
            across_reg  <= stas_pkg::TILE_W'(1);
            down_reg    <= stas_pkg::TILE_W'(1);
            twidth_reg  <= '0;
            theight_reg <= '0;
            loop_reg    <= 1'b0;
            fc_reg      <= '0;
            tile_reg    <= '0;
            end_reg     <= 1'b0;
            run_reg     <= 1'b0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    stas_pkg::REG_HORIZONTAL: horiz_reg   <= cfg.data[0];
                    stas_pkg::REG_FRAMES_PER: fpt_reg     <= cfg.data;
                    stas_pkg::REG_FRAMES_REP: fbr_reg     <= cfg.data;
                    stas_pkg::REG_TILES_ACR:  across_reg  <= cfg.data;
                    stas_pkg::REG_TILES_DOWN: down_reg    <= cfg.data;
                    stas_pkg::REG_TILE_WIDTH: twidth_reg  <= cfg.data[stas_pkg::PIXEL_W-1:0];
                    stas_pkg::REG_TILE_HGT:   theight_reg <= cfg.data[stas_pkg::PIXEL_W-1:0];
                    stas_pkg::REG_LOOP:       loop_reg    <= cfg.data[0];
                    default:                  loop_reg    <= loop_reg;
                endcase
            end
            if (accept)
            begin
                fc_reg   <= fc_next;
                tile_reg <= tile_next;
                end_reg  <= end_next;
                run_reg  <= run_next;
            end
            else if ((state_reg == S_MOD) && stat.done)
            begin
                tile_reg <= stat.result[stas_pkg::TILE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_tile_reg <= tile_reg;
            r_x_reg    <= horiz_reg ? stat.result : '0;
            r_y_reg    <= horiz_reg ? '0 : stat.result;
            r_anim_reg <= run_reg;
            r_end_reg  <= end_reg;
        end
    end

    assign res.valid      = rv_reg;
    assign res.tile_index = r_tile_reg;
    assign res.source_x   = r_x_reg;
    assign res.source_y   = r_y_reg;
    assign res.animating  = r_anim_reg;
    assign res.at_end     = r_end_reg;

endmodule

// ----- rtl/stas_iter_unit.sv -----
// Shared iterative unit: one adder serves restoring remainder and shift-add multiply.
module stas_iter_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stas_pkg::unit_req_t  req,
    output stas_pkg::unit_stat_t stat
);

    logic [stas_pkg::OFFSET_W-1:0] acc_reg, acc_next;
    logic [stas_pkg::OFFSET_W-1:0] sh_reg, sh_next;
    logic [stas_pkg::OPND_W-1:0]   opb_reg, opb_next;
    logic [stas_pkg::STEP_W-1:0]   step_reg, step_next;
    stas_pkg::op_t                 op_reg, op_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [stas_pkg::OPND_W-1:0]   trial;
    logic [stas_pkg::OFFSET_W:0]   add_a;
    logic [stas_pkg::OFFSET_W:0]   add_b;
    logic                          carry_in;
    logic [stas_pkg::OFFSET_W:0]   sum;

    always_comb
    begin
        trial = {acc_reg[stas_pkg::OPND_W-2:0], sh_reg[stas_pkg::OPND_W-1]};
        if (op_reg == stas_pkg::OP_MOD)
        begin
            add_a    = (stas_pkg::OFFSET_W+1)'(trial);
            add_b    = ~((stas_pkg::OFFSET_W+1)'(opb_reg));
            carry_in = 1'b1;
        end
        else
        begin
            add_a    = {1'b0, acc_reg};
            add_b    = opb_reg[0] ? {1'b0, sh_reg} : '0;
            carry_in = 1'b0;
        end
        sum = add_a + add_b + (stas_pkg::OFFSET_W+1)'(carry_in);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        opb_next  = opb_reg;
        step_next = step_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (op_reg == stas_pkg::OP_MOD)
            begin
                // keep the trial value when the subtract borrows
                acc_next = sum[stas_pkg::OFFSET_W] ? stas_pkg::OFFSET_W'(trial)
                                                   : sum[stas_pkg::OFFSET_W-1:0];
            end
            else
            begin
                acc_next = sum[stas_pkg::OFFSET_W-1:0];
                opb_next = opb_reg >> 1;
            end
            sh_next   = sh_reg << 1;
            step_next = step_reg - 1'b1;
            if (step_reg == stas_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            acc_next  = '0;
            sh_next   = stas_pkg::OFFSET_W'(req.opa);
            opb_next  = req.opb;
            op_next   = req.op;
            step_next = (req.op == stas_pkg::OP_MOD) ? stas_pkg::MOD_STEPS
                                                     : stas_pkg::MUL_STEPS;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            op_reg   <= stas_pkg::OP_MOD;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        opb_reg <= opb_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign stat.result = acc_reg;

endmodule

// ----- rtl/stas_checker.sv -----
// Port-level checker for the sprite tile animation sequencer, bound to the top level.
module stas_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [stas_pkg::TILE_W-1:0]   res_tile,
    input logic [stas_pkg::OFFSET_W-1:0] res_x,
    input logic [stas_pkg::OFFSET_W-1:0] res_y
);

    // a stalled result beat holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_tile) && $stable(res_x)
                                    && $stable(res_y);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result beat changed while stalled");

    // an accepted command occupies the sequencer
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("command accepted while previous one in flight");

    // a fresh result only comes out of a busy sequencer
    property p_result_from_work;
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cmd_ready);
    endproperty
    a_result_from_work: assert property (p_result_from_work)
        else $error("result appeared without work in progress");

    // only one sheet axis carries an offset
    property p_one_axis;
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_x == '0) || (res_y == '0);
    endproperty
    a_one_axis: assert property (p_one_axis) else $error("both offsets nonzero");

endmodule

bind sprite_tile_animation_sequencer stas_checker u_stas_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_tile  (res.tile_index),
    .res_x     (res.source_x),
    .res_y     (res.source_y)
);
